[src/sync_typed_frame_deframer_unit_assert.svh]
// Assertion macros used by the deframer parse core.
`ifndef SYNC_TYPED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define SYNC_TYPED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define STFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STFD_ASSERT(lbl, prop, msg)
`define STFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/stfd_pkg.sv]
// Types and constants of the typed frame deframer.
package stfd_pkg;

  localparam int NUM_CODES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int KIND_W    = 3;
  localparam int CNT_W     = 10;
  localparam int IDX_W     = 9;

  typedef logic [7:0] code_t;

  localparam code_t CODE_RESET [NUM_CODES] = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6};

  localparam code_t SYNC0_BYTE = 8'h55;
  localparam code_t SYNC1_BYTE = 8'hAA;

  localparam logic [KIND_W-1:0] K_SCAN = 3'd1;
  localparam logic [KIND_W-1:0] K_PATH = 3'd4;

  typedef enum logic [2:0] {
    PH_SYNC0,
    PH_SYNC1,
    PH_TYPE,
    PH_HEAD,
    PH_BORDER,
    PH_OBST,
    PH_PATH,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    RK_POINT,
    RK_OK,
    RK_BAD
  } res_kind_e;

  typedef enum logic [1:0] {
    PL_BORDER,
    PL_OBST,
    PL_PATH
  } point_list_e;

  typedef struct packed {
    logic  vld;
    code_t rx_byte;
  } step_t;

  typedef struct packed {
    res_kind_e          kind;
    logic [KIND_W-1:0]  frame_kind;
    logic [31:0]        time_stamp;
    logic [15:0]        word_a;
    logic [15:0]        word_b;
    logic [15:0]        word_c;
    logic [CNT_W-1:0]   first_count;
    logic [CNT_W-1:0]   second_count;
    point_list_e        point_list;
    logic [IDX_W-1:0]   point_index;
    logic [15:0]        point_x;
    logic [15:0]        point_y;
  } result_t;

endpackage

[src/stfd_byte_if.sv]
// Received byte channel.
interface stfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[src/stfd_res_if.sv]
// Result channel: points and frame status.
interface stfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  frame_kind;
  logic [31:0] time_stamp;
  logic [15:0] word_a;
  logic [15:0] word_b;
  logic [15:0] word_c;
  logic [9:0]  first_count;
  logic [9:0]  second_count;
  logic [1:0]  point_list;
  logic [8:0]  point_index;
  logic [15:0] point_x;
  logic [15:0] point_y;

  modport source (output valid, output kind, output frame_kind, output time_stamp,
                  output word_a, output word_b, output word_c, output first_count,
                  output second_count, output point_list, output point_index,
                  output point_x, output point_y, input ready);
  modport sink (input valid, input kind, input frame_kind, input time_stamp,
                input word_a, input word_b, input word_c, input first_count,
                input second_count, input point_list, input point_index,
                input point_x, input point_y, output ready);
endinterface

[src/stfd_cfg_if.sv]
// Configuration write channel.
interface stfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/sync_typed_frame_deframer_unit.sv]
// Typed frame deframer: top level with type code registers.
// Path: a received byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle, set by the single parse step between the input
// register and the result register; a result held by the sink stalls the parse step.
// Reset: type codes return to 1..6, all parse state clears and the hunt for 0x55
// starts; no clearing pass.
module sync_typed_frame_deframer_unit #(
  parameter int unsigned BORDER_CAPACITY   = 360,
  parameter int unsigned OBSTACLE_CAPACITY = 360,
  parameter int unsigned PATH_CAPACITY     = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stfd_byte_if.sink   rx_i,
  stfd_cfg_if.sink    cfg_i,
  stfd_res_if.source  res_o
);
  import stfd_pkg::*;

  code_t   codes_q [NUM_CODES];
  code_t   codes_d [NUM_CODES];
  step_t   step;
  logic    out_free;
  logic    res_vld;
  result_t res;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    codes_d = codes_q;
    if (cfg_i.valid) begin
      for (int i = 0; i < NUM_CODES; i++) begin
        if (cfg_i.index == CFG_IDX_W'(i)) codes_d[i] = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q <= CODE_RESET;
    end else begin
      codes_q <= codes_d;
    end
  end

  stfd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx_i),
    .out_free_i (out_free),
    .step_o     (step)
  );

  stfd_parse_core #(
    .BORDER_CAPACITY   (BORDER_CAPACITY),
    .OBSTACLE_CAPACITY (OBSTACLE_CAPACITY),
    .PATH_CAPACITY     (PATH_CAPACITY)
  ) u_parse_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .codes_i   (codes_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  stfd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_vld_i  (res_vld),
    .res_i      (res),
    .out_free_o (out_free),
    .res_o      (res_o)
  );
endmodule

[src/stfd_in_reg.sv]
// Input register for received bytes.
module stfd_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  stfd_byte_if.sink        rx_i,
  input  logic             out_free_i,
  output stfd_pkg::step_t  step_o
);
  import stfd_pkg::*;

  logic  vld_q, vld_d;
  code_t byte_q;
  logic  adv;

  assign adv        = vld_q && out_free_i;
  assign rx_i.ready = !vld_q || out_free_i;
  assign step_o     = '{vld: adv, rx_byte: byte_q};

  always_comb begin
    vld_d = vld_q;
    if (rx_i.valid && rx_i.ready) begin
      vld_d = 1'b1;
    end else if (adv) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end
endmodule

[src/stfd_parse_core.sv]
// Frame parser: phase tracking, field assembly and result generation.
`include "sync_typed_frame_deframer_unit_assert.svh"

module stfd_parse_core #(
  parameter int unsigned BORDER_CAPACITY   = 360,
  parameter int unsigned OBSTACLE_CAPACITY = 360,
  parameter int unsigned PATH_CAPACITY     = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stfd_pkg::step_t   step_i,
  input  stfd_pkg::code_t   codes_i [stfd_pkg::NUM_CODES],
  output logic              res_vld_o,
  output stfd_pkg::result_t res_o
);
  import stfd_pkg::*;

  localparam logic [CNT_W-1:0] BCAP = CNT_W'(BORDER_CAPACITY);
  localparam logic [CNT_W-1:0] OCAP = CNT_W'(OBSTACLE_CAPACITY);
  localparam logic [CNT_W-1:0] PCAP = CNT_W'(PATH_CAPACITY);
  localparam logic [3:0] HEAD_LAST_SCAN  = 4'd7;
  localparam logic [3:0] HEAD_LAST_PATH  = 4'd5;
  localparam logic [3:0] HEAD_LAST_OTHER = 4'd9;

  phase_e            phase_q, phase_d;
  logic [7:0]        sum_q, sum_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [3:0]        pos_q, pos_d;
  logic [31:0]       time_q, time_d;
  logic [15:0]       word_q [3];
  logic [15:0]       word_d [3];
  logic [15:0]       cnt_q [2];
  logic [15:0]       cnt_d [2];
  logic [15:0]       left_q, left_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [23:0]       asm_q, asm_d;

  code_t             b;
  logic [7:0]        sum_add;
  logic              type_hit;
  logic [KIND_W-1:0] type_idx;
  logic              head_last;
  logic              pt_last;
  logic              list_end;
  logic [3:0]        off;
  logic [CNT_W-1:0]  cap;
  logic              entering;

  assign b       = step_i.rx_byte;
  assign sum_add = sum_q + b;
  assign off     = pos_q - 4'd4;

  always_comb begin
    type_hit = 1'b0;
    type_idx = '0;
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      if (codes_i[k] == b) begin
        type_hit = 1'b1;
        type_idx = KIND_W'(k);
      end
    end
  end

  always_comb begin
    if (kind_q == K_SCAN) begin
      head_last = (pos_q == HEAD_LAST_SCAN);
    end else if (kind_q == K_PATH) begin
      head_last = (pos_q == HEAD_LAST_PATH);
    end else begin
      head_last = (pos_q == HEAD_LAST_OTHER);
    end
    pt_last  = (phase_q == PH_PATH) ? (pos_q == 4'd1) : (pos_q == 4'd3);
    list_end = pt_last && (left_q == 16'd1);
    case (phase_q)
      PH_BORDER: cap = BCAP;
      PH_OBST:   cap = OCAP;
      default:   cap = PCAP;
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i.vld) begin
      case (phase_q)
        PH_SYNC0: if (b == SYNC0_BYTE) phase_d = PH_SYNC1;
        PH_SYNC1: phase_d = (b == SYNC1_BYTE) ? PH_TYPE : PH_SYNC0;
        PH_TYPE:  phase_d = type_hit ? PH_HEAD : PH_SYNC0;
        PH_HEAD: begin
          if (head_last) begin
            if (kind_q == K_SCAN) begin
              if (cnt_d[0] != 16'd0) begin
                phase_d = PH_BORDER;
              end else if (cnt_d[1] != 16'd0) begin
                phase_d = PH_OBST;
              end else begin
                phase_d = PH_CHECK;
              end
            end else if (kind_q == K_PATH) begin
              phase_d = (cnt_d[0] != 16'd0) ? PH_PATH : PH_CHECK;
            end else begin
              phase_d = PH_CHECK;
            end
          end
        end
        PH_BORDER: begin
          if (list_end) phase_d = (cnt_q[1] != 16'd0) ? PH_OBST : PH_CHECK;
        end
        PH_OBST, PH_PATH: begin
          if (list_end) phase_d = PH_CHECK;
        end
        PH_CHECK: phase_d = PH_SYNC0;
        default:  phase_d = PH_SYNC0;
      endcase
    end
  end

  assign entering = step_i.vld && (((phase_q == PH_HEAD) && head_last) ||
                                   ((phase_q == PH_BORDER) && list_end));

  // datapath and results
  always_comb begin
    sum_d     = sum_q;
    kind_d    = kind_q;
    pos_d     = pos_q;
    time_d    = time_q;
    word_d    = word_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    ptr_d     = ptr_q;
    asm_d     = asm_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (step_i.vld) begin
      case (phase_q)
        PH_SYNC0: if (b == SYNC0_BYTE) sum_d = b;
        PH_SYNC1: sum_d = sum_add;
        PH_TYPE: begin
          sum_d = sum_add;
          if (type_hit) begin
            kind_d = type_idx;
            time_d = '0;
            word_d = '{16'd0, 16'd0, 16'd0};
            cnt_d  = '{16'd0, 16'd0};
            pos_d  = '0;
          end
        end
        PH_HEAD: begin
          sum_d = sum_add;
          pos_d = pos_q + 4'd1;
          if (pos_q < 4'd4) begin
            time_d[pos_q[1:0]*8 +: 8] = b;
          end else if ((kind_q == K_SCAN) || (kind_q == K_PATH)) begin
            if (off[3:1] < 3'd2) begin
              if (off[0]) cnt_d[off[1]][15:8] = b;
              else        cnt_d[off[1]][7:0]  = b;
            end
          end else if (off[3:1] < 3'd3) begin
            if (off[0]) word_d[off[2:1]][15:8] = b;
            else        word_d[off[2:1]][7:0]  = b;
          end
          if (head_last) pos_d = '0;
        end
        PH_BORDER, PH_OBST, PH_PATH: begin
          sum_d = sum_add;
          pos_d = pos_q + 4'd1;
          if (pos_q[1:0] != 2'd3) asm_d[pos_q[1:0]*8 +: 8] = b;
          if (pt_last) begin
            if (ptr_q < cap) begin
              res_vld_o         = 1'b1;
              res_o.kind        = RK_POINT;
              res_o.frame_kind  = kind_q;
              res_o.time_stamp  = time_q;
              res_o.point_index = ptr_q[IDX_W-1:0];
              case (phase_q)
                PH_BORDER: res_o.point_list = PL_BORDER;
                PH_OBST:   res_o.point_list = PL_OBST;
                default:   res_o.point_list = PL_PATH;
              endcase
              if (phase_q == PH_PATH) begin
                res_o.point_x = {8'd0, asm_q[7:0]};
                res_o.point_y = {8'd0, b};
              end else begin
                res_o.point_x = asm_q[15:0];
                res_o.point_y = {b, asm_q[23:16]};
              end
              ptr_d = ptr_q + 10'd1;
            end
            left_d = left_q - 16'd1;
            asm_d  = '0;
            pos_d  = '0;
          end
        end
        PH_CHECK: begin
          sum_d            = sum_add;
          pos_d            = '0;
          res_vld_o        = 1'b1;
          res_o.kind       = (sum_add == 8'd0) ? RK_OK : RK_BAD;
          res_o.frame_kind = kind_q;
          res_o.time_stamp = time_q;
          res_o.word_a     = word_q[0];
          res_o.word_b     = word_q[1];
          res_o.word_c     = word_q[2];
          if (kind_q == K_SCAN) begin
            res_o.first_count  = (cnt_q[0] < {6'd0, BCAP}) ? cnt_q[0][CNT_W-1:0] : BCAP;
            res_o.second_count = (cnt_q[1] < {6'd0, OCAP}) ? cnt_q[1][CNT_W-1:0] : OCAP;
          end else if (kind_q == K_PATH) begin
            res_o.first_count  = (cnt_q[0] < {6'd0, PCAP}) ? cnt_q[0][CNT_W-1:0] : PCAP;
          end
        end
        default: sum_d = sum_q;
      endcase
      if (entering) begin
        left_d = ((phase_q == PH_BORDER) || (cnt_d[0] == 16'd0)) ? cnt_d[1] : cnt_d[0];
        ptr_d  = '0;
        asm_d  = '0;
        pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC0;
      sum_q   <= '0;
      kind_q  <= '0;
      pos_q   <= '0;
      time_q  <= '0;
      word_q  <= '{16'd0, 16'd0, 16'd0};
      cnt_q   <= '{16'd0, 16'd0};
      left_q  <= '0;
      ptr_q   <= '0;
      asm_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      time_q  <= time_d;
      word_q  <= word_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      ptr_q   <= ptr_d;
      asm_q   <= asm_d;
    end
  end

  `STFD_ASSERT(a_res_phase, res_vld_o |-> (step_i.vld && (phase_q == PH_BORDER || phase_q == PH_OBST || phase_q == PH_PATH || phase_q == PH_CHECK)), "result outside point or check phase")
  `STFD_ASSERT(a_check_ends, (step_i.vld && phase_q == PH_CHECK) |=> (phase_q == PH_SYNC0), "frame did not end after checksum")
  `STFD_ASSERT(a_left_live, (phase_q == PH_BORDER || phase_q == PH_OBST || phase_q == PH_PATH) |-> (left_q != 16'd0), "point phase with no points left")
  `STFD_ASSERT_ALWAYS(a_idle_hold, (rst_ni && !step_i.vld) |=> $stable(phase_q), "phase moved without a byte")

endmodule

[src/stfd_out_reg.sv]
// Result register towards the result channel.
module stfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_vld_i,
  input  stfd_pkg::result_t res_i,
  output logic              out_free_o,
  stfd_res_if.source        res_o
);
  import stfd_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  assign out_free_o = !vld_q || res_o.ready;
  assign vld_d      = out_free_o ? res_vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid        = vld_q;
  assign res_o.kind         = res_q.kind;
  assign res_o.frame_kind   = res_q.frame_kind;
  assign res_o.time_stamp   = res_q.time_stamp;
  assign res_o.word_a       = res_q.word_a;
  assign res_o.word_b       = res_q.word_b;
  assign res_o.word_c       = res_q.word_c;
  assign res_o.first_count  = res_q.first_count;
  assign res_o.second_count = res_q.second_count;
  assign res_o.point_list   = res_q.point_list;
  assign res_o.point_index  = res_q.point_index;
  assign res_o.point_x      = res_q.point_x;
  assign res_o.point_y      = res_q.point_y;
endmodule
